// File: design/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// types, constants and tables shared by the odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int unsigned CordicStepsDefault = 24;
    localparam logic [31:0] MptReset  = 32'd2066524;
    localparam logic [31:0] IwbReset  = 32'd48629616;
    localparam logic [31:0] GainQ32   = 32'd2608131497;
    localparam logic [29:0] BaPerRadQ16 = 30'd683565276;
    localparam logic [19:0] UsPerS    = 20'd1000000;

    localparam logic [0:0] RegMpt = 1'b0;
    localparam logic [0:0] RegIwb = 1'b1;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [23:0]        elapsed_us;
    } ddo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic               speed_valid;
    } ddo_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LDIST, ST_RDIST, ST_TURN, ST_ANGLE, ST_GAIN,
        ST_CORDIC, ST_LDIV, ST_ADIV, ST_DONE
    } ddo_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic init_cordic;
        logic init_ldiv;
        logic init_adiv;
        logic commit;
    } ddo_cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic div_last;
    } ddo_sts_t;

    function automatic logic [31:0] atan_ba(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                5'd24: r = 32'd41;
                5'd25: r = 32'd20;
                5'd26: r = 32'd10;
                5'd27: r = 32'd5;
                5'd28: r = 32'd3;
                5'd29: r = 32'd1;
                5'd30: r = 32'd1;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: design/ddo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer for one odometry update
// ----------------------------------------------------------------------------
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_busy,
    input  ddo_sts_t sts,
    output ddo_cmd_t cmd,
    output logic     busy
);

    ddo_state_t state_reg;
    ddo_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_LDIST;
                end
            end
            ST_LDIST:
            begin
                cmd.step = 1'b1;
                state_next = ST_RDIST;
            end
            ST_RDIST:
            begin
                cmd.step = 1'b1;
                state_next = ST_TURN;
            end
            ST_TURN:
            begin
                cmd.step = 1'b1;
                state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                cmd.step = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.init_cordic = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.step = 1'b1;
                if (sts.cordic_last)
                begin
                    cmd.init_ldiv = 1'b1;
                    state_next = ST_LDIV;
                end
            end
            ST_LDIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.init_adiv = 1'b1;
                    state_next = ST_ADIV;
                end
            end
            ST_ADIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !out_busy)
        else $error("commit over pending beat");
    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_LDIST)
        else $error("load did not start");

endmodule

// File: design/ddo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_dp
// datapath: distances, turn, cordic rotation, speed division
// ----------------------------------------------------------------------------
module ddo_dp
    import ddo_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ddo_cmd_t    cmd,
    input  ddo_in_t     in_beat,
    input  logic [31:0] mpt,
    input  logic [31:0] iwb,
    output ddo_sts_t    sts,
    output ddo_out_t    res
);

    localparam int unsigned IW = $clog2(CORDIC_STEPS + 1);

    logic [31:0] last_l_reg, last_r_reg, acc_x_reg, acc_y_reg, acc_h_reg;
    logic [31:0] lc_reg, rc_reg;
    logic [23:0] us_reg;
    logic [3:0]  ph_reg;
    logic signed [32:0] ld_reg, rd_reg;
    logic signed [31:0] mean_reg;
    logic signed [33:0] diff_reg;
    logic [40:0] tm_reg;
    logic        tneg_reg;
    logic [31:0] full_reg, half_reg;
    logic signed [34:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [IW-1:0] it_reg;
    logic [5:0]  dcnt_reg;
    logic [63:0] num_reg;
    logic [24:0] rem_reg;
    logic [63:0] quo_reg;
    logic        dneg_reg;
    logic signed [31:0] lin_reg, ang_reg;

    // distance stage, shared for both wheels
    logic [31:0] dl;
    logic        dneg;
    logic [31:0] dmag;
    logic [63:0] dprod;
    logic [47:0] dm;
    logic signed [32:0] dsat;
    always_comb
    begin
        dl = (ph_reg == 4'd0) ? lc_reg - last_l_reg : rc_reg - last_r_reg;
        dneg = dl[31];
        dmag = dneg ? 32'd0 - dl : dl;
        dprod = dmag * mpt;
        dm = 48'((dprod + 64'd32768) >> 16);
        if (dneg)
            dsat = (dm > 48'd2147483648) ? -33'sd2147483648 : -$signed({1'b0, dm[31:0]});
        else
            dsat = (dm > 48'd2147483647) ? 33'sd2147483647 : $signed({1'b0, dm[31:0]});
    end

    logic [33:0] dmg;
    logic [65:0] tprod;
    logic [70:0] bprod;
    logic signed [33:0] msum;
    logic [31:0] mmag;
    logic [63:0] gprod;
    logic [31:0] xm;
    logic [31:0] dir0;
    logic signed [34:0] xi;
    always_comb
    begin
        dmg = diff_reg[33] ? 34'(-diff_reg) : 34'(diff_reg);
        tprod = dmg * iwb;
        bprod = tm_reg * BaPerRadQ16;
        msum = 34'(rd_reg) + 34'(ld_reg);
        mmag = mean_reg[31] ? 32'd0 - mean_reg : mean_reg;
        gprod = mmag * GainQ32;
        xm = 32'((gprod + 64'd2147483648) >> 32);
        xi = mean_reg[31] ? -$signed({3'b0, xm}) : $signed({3'b0, xm});
        dir0 = acc_h_reg + half_reg;
    end

    logic signed [34:0] xs, ys;
    logic [31:0] at;
    always_comb
    begin
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        at = atan_ba(5'(it_reg));
    end

    logic [25:0] trial;
    assign trial = {rem_reg, num_reg[63]} - {1'b0, us_reg};
    assign sts.cordic_last = (it_reg == IW'(CORDIC_STEPS - 1));
    assign sts.div_last = (dcnt_reg == 6'd0);

    logic [64:0] qfin;
    logic signed [31:0] qsat;
    always_comb
    begin
        qfin = {quo_reg[63:0], ~trial[25]};
        if (dneg_reg)
            qsat = (qfin > 65'd2147483648) ? 32'sh80000000 : 32'(-qfin);
        else
            qsat = (qfin > 65'd2147483647) ? 32'sh7fffffff : 32'(qfin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_l_reg <= '0;
            last_r_reg <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_h_reg <= '0;
            ph_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                lc_reg <= in_beat.left_count;
                rc_reg <= in_beat.right_count;
                us_reg <= in_beat.elapsed_us;
                ph_reg <= '0;
            end
            else if (cmd.step && ph_reg < 4'd4)
            begin
                ph_reg <= ph_reg + 4'd1;
                case (ph_reg)
                    4'd0: ld_reg <= dsat;
                    4'd1:
                    begin
                        rd_reg <= dsat;
                    end
                    4'd2:
                    begin
                        mean_reg <= 32'(msum / 2);
                        diff_reg <= 34'(rd_reg) - 34'(ld_reg);
                    end
                    default:
                    begin
                        tm_reg <= 41'((tprod + 66'd8388608) >> 24);
                        tneg_reg <= diff_reg[33];
                    end
                endcase
            end
            if (cmd.init_cordic)
            begin
                full_reg <= tneg_reg ? 32'd0 - bprod[47:16] : bprod[47:16];
                half_reg <= tneg_reg ? 32'd0 - bprod[48:17] : bprod[48:17];
            end
            if (cmd.commit)
            begin
                acc_x_reg <= acc_x_reg + x_reg[31:0];
                acc_y_reg <= acc_y_reg + y_reg[31:0];
                acc_h_reg <= acc_h_reg + full_reg;
                last_l_reg <= lc_reg;
                last_r_reg <= rc_reg;
            end
        end
    end

    // cordic and divider registers
    logic cordic_run_reg;
    logic [31:0] dirf;
    always_comb
    begin
        dirf = ((dir0 + 32'h40000000) & 32'h80000000) != 0 ? dir0 - 32'h80000000 : dir0;
    end

    logic [0:0] gstage_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cordic_run_reg <= 1'b0;
            gstage_reg <= '0;
        end
        else
        begin
            gstage_reg <= cmd.init_cordic;
            cordic_run_reg <= cmd.init_cordic ? 1'b1 :
                (cmd.step && sts.cordic_last) ? 1'b0 : cordic_run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_cordic)
        begin
            it_reg <= '0;
        end
        else if (gstage_reg[0])
        begin
            x_reg <= ((dir0 + 32'h40000000) & 32'h80000000) != 0 ? -xi : xi;
            y_reg <= '0;
            z_reg <= 34'($signed(dirf));
        end
        else if (cmd.step && cordic_run_reg)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - $signed({2'b0, at});
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + $signed({2'b0, at});
            end
            it_reg <= it_reg + IW'(1);
        end

        if (cmd.init_ldiv || cmd.init_adiv)
        begin
            dcnt_reg <= 6'd63;
            rem_reg <= '0;
            quo_reg <= '0;
            if (cmd.init_ldiv)
            begin
                num_reg <= 64'(mmag) * 64'(UsPerS);
                dneg_reg <= mean_reg[31];
            end
            else
            begin
                num_reg <= 64'(tm_reg) * 64'(UsPerS);
                dneg_reg <= tneg_reg;
                lin_reg <= qsat;
            end
        end
        else if (cmd.step && !cordic_run_reg)
        begin
            rem_reg <= trial[25] ? {rem_reg[23:0], num_reg[63]} : trial[24:0];
            quo_reg <= {quo_reg[62:0], ~trial[25]};
            num_reg <= {num_reg[62:0], 1'b0};
            dcnt_reg <= dcnt_reg - 6'd1;
            if (sts.div_last && !cmd.init_adiv)
                ang_reg <= qsat;
        end
    end

    always_comb
    begin
        res.pos_x = acc_x_reg + x_reg[31:0];
        res.pos_y = acc_y_reg + y_reg[31:0];
        res.heading = acc_h_reg + full_reg;
        res.speed_valid = (us_reg != 24'd0);
        res.linear_speed = res.speed_valid ? lin_reg : '0;
        res.angular_speed = res.speed_valid ? ang_reg : '0;
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.init_ldiv || cmd.init_adiv) |=> dcnt_reg == 6'd63)
        else $error("divider count not loaded");
    a_cordic_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cordic_run_reg && sts.cordic_last) |=> !cordic_run_reg)
        else $error("cordic overran");
    a_gain_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_cordic |=> gstage_reg[0])
        else $error("gain stage lost");

endmodule

// File: design/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// wheel encoder odometry: pose by cordic, speeds by restoring division
// ----------------------------------------------------------------------------
// channel   signals                          beat
// in        in_valid in_ready in_data        encoder counts and elapsed time
// out       out_valid out_ready out_data     pose and speeds
// cfg       cfg_we cfg_index cfg_data        register write, no wait
//
// one item passes through the cordic stage and then the bit-serial
// speed divider, once for the linear and once for the angular speed
// in_ready is low while an item is being worked on
// output register holds the beat; next item is taken while it waits
// reset clears pose, last counts and loads register defaults
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  ddo_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output ddo_out_t    out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] mpt_reg, iwb_reg;
    logic        out_valid_reg;
    ddo_out_t    out_reg;
    ddo_cmd_t    cmd;
    ddo_sts_t    sts;
    ddo_out_t    res;
    logic        busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg <= MptReset;
            iwb_reg <= IwbReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == RegMpt)
                mpt_reg <= cfg_data;
            if (cfg_we && cfg_index == RegIwb)
                iwb_reg <= cfg_data;
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            out_reg <= res;
    end

    assign in_ready = !busy;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && in_ready),
        .out_busy (out_valid_reg && !out_ready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_beat (in_data),
        .mpt     (mpt_reg),
        .iwb     (iwb_reg),
        .sts     (sts),
        .res     (res)
    );

endmodule
